// ----- sv/rrls_pkg.sv -----
// ----------------------------------------------------------------------------
// rrls_pkg: shared types and constants for the RPC reply latency stats table
// Command codes, entry layout, queue item and the per-entry record.
// ----------------------------------------------------------------------------
package rrls_pkg;

   localparam int PROC_ENTRIES = 256;
   localparam int IDX_W        = $clog2(PROC_ENTRIES);
   localparam int CNT_W        = IDX_W + 1;

   localparam logic [29:0] NS_PER_S   = 30'd1000000000;
   localparam logic [63:0] SECS_TO_10US = 64'd100000;
   localparam logic [29:0] NS_PER_10US  = 30'd10000;
   localparam logic [9:0]  NS_PER_US    = 10'd1000;
   // x / 10000 == (x * NS_10US_RECIP) >> NS_10US_SHIFT for any 32-bit x
   localparam logic [31:0] NS_10US_RECIP = 32'd3518437209;
   localparam int          NS_10US_SHIFT = 45;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_PROGRAM = 2'd0,
      CSR_VERSION = 2'd1,
      CSR_PROC_COUNT = 2'd2
   } csr_idx_type;

   // Front to back: a classified item with the normalized delay.
   typedef struct packed {
      cmd_type            op;      // CMD_NONE: emit a zero result
      logic               hit;     // sample counted / read index valid
      logic [IDX_W-1:0]   idx;
      logic [31:0]        ds;
      logic [29:0]        dn;
   } work_type;

   localparam int ENTRY_W = 32 + 32 + 30 + 32 + 30 + 48 + 30;

   typedef struct packed {
      logic [31:0] count;
      logic [31:0] min_s;
      logic [29:0] min_n;
      logic [31:0] max_s;
      logic [29:0] max_n;
      logic [47:0] tot_s;
      logic [29:0] tot_n;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_AVG,
      ST_DIV,
      ST_CLEAR,
      ST_EMIT
   } back_state_type;

   // Signed-seconds, unsigned-nanoseconds ordering: a < b
   function automatic logic time_less(logic [31:0] as, logic [29:0] an,
                                      logic [31:0] bs, logic [29:0] bn);
      time_less = ($signed(as) < $signed(bs)) || (as == bs && an < bn);
   endfunction

endpackage

// ----- sv/rrls_ram.sv -----
// ----------------------------------------------------------------------------
// rrls_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rrls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ----- sv/rrls_front.sv -----
// ----------------------------------------------------------------------------
// rrls_front: item intake and classification
// Matches program, version and index, and normalizes the reply delay.
// ----------------------------------------------------------------------------
module rrls_front import rrls_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_command,
   input  logic [7:0]    req_procedure,
   input  logic          req_is_request,
   input  logic [31:0]   req_packet_program,
   input  logic [31:0]   req_packet_version,
   input  logic [31:0]   req_reply_secs,
   input  logic [19:0]   req_reply_usecs,
   input  logic [31:0]   req_call_secs,
   input  logic [29:0]   req_call_nsecs,
   input  logic [31:0]   prog_ff,
   input  logic [31:0]   vers_ff,
   input  logic [8:0]    pcount_ff,
   output logic          wk_valid,
   input  logic          wk_stall,
   output work_type      wk_item
);

   logic       valid_ff, valid_in;
   work_type   item_ff, item_in;
   logic       take;
   logic       idx_ok;
   logic signed [32:0] dn0;   // range -2^30 .. ~1.05e9
   logic [31:0] ds0;
   logic signed [32:0] dn1, dn2;
   logic [31:0] ds1, ds2;
   logic signed [32:0] nsps;

   assign req_stall = valid_ff && wk_stall;
   assign take      = req_valid && !req_stall;
   assign nsps      = 33'(NS_PER_S);

   always_comb begin
      idx_ok = ({1'b0, req_procedure} < pcount_ff)
         && (32'(req_procedure) < 32'(PROC_ENTRIES));
      ds0 = req_reply_secs - req_call_secs;
      dn0 = $signed(33'(req_reply_usecs * 30'(NS_PER_US))) - $signed({3'b0, req_call_nsecs});
      // at most two normalization steps either way for any field bits
      dn1 = dn0; ds1 = ds0;
      if (dn0 < 0) begin
         dn1 = dn0 + nsps; ds1 = ds0 - 32'd1;
      end else if (dn0 >= nsps) begin
         dn1 = dn0 - nsps; ds1 = ds0 + 32'd1;
      end
      dn2 = dn1; ds2 = ds1;
      if (dn1 < 0) begin
         dn2 = dn1 + nsps; ds2 = ds1 - 32'd1;
      end else if (dn1 >= nsps) begin
         dn2 = dn1 - nsps; ds2 = ds1 + 32'd1;
      end
   end

   always_comb begin
      item_in.op  = cmd_type'(req_command);
      item_in.idx = IDX_W'(req_procedure);
      item_in.ds  = ds2;
      item_in.dn  = dn2[29:0];
      case (cmd_type'(req_command))
         CMD_SAMPLE: item_in.hit = idx_ok && !req_is_request
            && req_packet_program == prog_ff && req_packet_version == vers_ff;
         CMD_READ:   item_in.hit = idx_ok;
         CMD_CLEAR:  item_in.hit = 1'b1;
         default:    item_in.hit = 1'b0;
      endcase
      valid_in = take || (valid_ff && wk_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign wk_valid = valid_ff;
   assign wk_item  = item_ff;

endmodule

// ----- sv/rrls_queue.sv -----
// ----------------------------------------------------------------------------
// rrls_queue: two-entry queue between front and back
// ----------------------------------------------------------------------------
module rrls_queue import rrls_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  work_type in_item,
   output logic     out_valid,
   input  logic     out_take,
   output work_type out_item
);

   work_type  slot_ff [2];
   logic      wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] fill_ff, fill_in;
   logic      push;

   assign in_stall  = (fill_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (fill_ff != 2'd0);
   assign out_item  = slot_ff[rp_ff];

   always_comb begin
      wp_in   = wp_ff ^ push;
      rp_in   = rp_ff ^ (out_take && out_valid);
      fill_in = fill_ff + 2'(push) - 2'(out_take && out_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; fill_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; fill_ff <= fill_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= in_item;
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3) else $error("queue fill out of range");

endmodule

// ----- sv/rrls_back.sv -----
// ----------------------------------------------------------------------------
// rrls_back: table update, read and clear engine
// Read-modify-write of one entry per sample, averaging divider for reads,
// sweep for clears.
// ----------------------------------------------------------------------------
module rrls_back import rrls_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           wk_valid,
   output logic           wk_take,
   input  work_type       wk_item,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           rsp_accepted,
   output logic [31:0]    rsp_call_count,
   output logic signed [31:0] rsp_min_secs,
   output logic [29:0]    rsp_min_nsecs,
   output logic signed [31:0] rsp_max_secs,
   output logic [29:0]    rsp_max_nsecs,
   output logic [63:0]    rsp_avg_10us
);

   back_state_type state_ff, state_in;
   work_type   cur_ff, cur_in;
   entry_type  rd_entry, upd, wr_data;
   logic       wr_en;
   logic [IDX_W-1:0] addr;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic       init_ff, init_in;   // clearing pass after reset
   logic [63:0] num_ff, num_in, quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [6:0]  bit_ff, bit_in;
   logic [63:0] prod_ff, prod_in;
   logic [29:0] ndiv_ff, ndiv_in;
   logic [61:0] nrecip;
   logic [33:0] trial;
   logic       out_valid_ff, out_valid_in;
   logic       res_acc_ff, res_acc_in;
   entry_type  res_ff, res_in;
   logic [63:0] avg_ff, avg_in;
   logic [31:0] ms, xs;
   logic [29:0] mn, xn;
   logic [47:0] ts;
   logic [30:0] tn;
   logic       out_free;

   rrls_ram #(.WIDTH(ENTRY_W), .DEPTH(PROC_ENTRIES)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (addr),
      .wr_data(wr_data),
      .rd_data(rd_entry)
   );

   assign out_free = !out_valid_ff || !rsp_stall;

   // entry update for a counted sample
   always_comb begin
      ms = rd_entry.min_s; mn = rd_entry.min_n;
      xs = rd_entry.max_s; xn = rd_entry.max_n;
      if (xs == 32'd0 && xn == 30'd0) begin
         xs = cur_ff.ds; xn = cur_ff.dn;
      end
      if (ms == 32'd0 && mn == 30'd0) begin
         ms = cur_ff.ds; mn = cur_ff.dn;
      end
      if (time_less(cur_ff.ds, cur_ff.dn, ms, mn)) begin
         ms = cur_ff.ds; mn = cur_ff.dn;
      end
      if (time_less(xs, xn, cur_ff.ds, cur_ff.dn)) begin
         xs = cur_ff.ds; xn = cur_ff.dn;
      end
      tn = 31'(rd_entry.tot_n) + 31'(cur_ff.dn);
      ts = rd_entry.tot_s + {{16{cur_ff.ds[31]}}, cur_ff.ds};
      if (tn >= 31'(NS_PER_S)) begin
         tn = tn - 31'(NS_PER_S);
         ts = ts + 48'd1;
      end
      upd.count = rd_entry.count + 32'd1;
      upd.min_s = ms; upd.min_n = mn;
      upd.max_s = xs; upd.max_n = xn;
      upd.tot_s = ts; upd.tot_n = tn[29:0];
   end

   assign trial  = {rem_ff, num_ff[63]} - {2'b0, res_ff.count};
   assign nrecip = rd_entry.tot_n * NS_10US_RECIP;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!init_ff && wk_valid) begin
               if (!wk_item.hit) state_in = ST_EMIT;
               else if (wk_item.op == CMD_CLEAR) state_in = ST_CLEAR;
               else state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            // a read loads the result register; wait until it has drained
            if (cur_ff.op == CMD_SAMPLE) state_in = ST_UPDATE;
            else if (out_free) state_in = ST_AVG;
         end
         ST_UPDATE: state_in = ST_EMIT;
         ST_AVG:    state_in = ST_DIV;
         ST_DIV:    if (bit_ff == 7'd0 || res_ff.count == 32'd0) state_in = ST_EMIT;
         ST_CLEAR:  if (sweep_ff == IDX_W'(PROC_ENTRIES - 1)) state_in = ST_EMIT;
         ST_EMIT:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      wk_take  = (state_ff == ST_IDLE) && !init_ff && wk_valid;
      cur_in   = wk_take ? wk_item : cur_ff;
      addr     = cur_in.idx;
      wr_en    = 1'b0;
      wr_data  = upd;
      sweep_in = sweep_ff;
      init_in  = init_ff;
      res_in   = res_ff;
      num_in   = num_ff; quo_in = quo_ff; rem_in = rem_ff; bit_in = bit_ff;
      prod_in  = prod_ff; ndiv_in = ndiv_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      res_acc_in   = res_acc_ff;
      avg_in       = avg_ff;
      if (init_ff) begin
         addr = sweep_ff; wr_en = 1'b1; wr_data = '0;
         sweep_in = sweep_ff + IDX_W'(1);
         if (sweep_ff == IDX_W'(PROC_ENTRIES - 1)) init_in = 1'b0;
      end
      case (state_ff)
         ST_UPDATE: begin
            addr = cur_ff.idx; wr_en = 1'b1; wr_data = upd;
         end
         ST_AVG: begin
            res_in  = rd_entry;
            prod_in = {{16{rd_entry.tot_s[47]}}, rd_entry.tot_s} * SECS_TO_10US;
            ndiv_in = 30'(nrecip[61:NS_10US_SHIFT]);
            bit_in  = 7'd64;
            rem_in  = '0;
            quo_in  = '0;
         end
         ST_DIV: begin
            if (bit_ff == 7'd64) begin
               num_in = prod_ff + 64'(ndiv_ff);
               bit_in = 7'd63;
            end else begin
               // one quotient bit per cycle, restoring
               if (!trial[33]) begin
                  rem_in = trial[32:0];
                  quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[31:0], num_ff[63]};
                  quo_in = {quo_ff[62:0], 1'b0};
               end
               num_in = {num_ff[62:0], 1'b0};
               bit_in = bit_ff - 7'd1;
            end
         end
         ST_CLEAR: begin
            addr = sweep_ff; wr_en = 1'b1; wr_data = '0;
            sweep_in = sweep_ff + IDX_W'(1);
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               res_acc_in   = cur_ff.hit;
               if (cur_ff.op == CMD_READ && cur_ff.hit) begin
                  avg_in = (res_ff.count == 32'd0) ? 64'd0 : quo_ff;
               end else begin
                  res_in = '0;
                  avg_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         init_ff      <= 1'b1;
         sweep_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         sweep_ff     <= sweep_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff  <= cur_in;
      res_ff  <= res_in;
      num_ff  <= num_in; quo_ff <= quo_in; rem_ff <= rem_in; bit_ff <= bit_in;
      prod_ff <= prod_in; ndiv_ff <= ndiv_in;
      res_acc_ff <= res_acc_in;
      avg_ff  <= avg_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_accepted   = res_acc_ff;
   assign rsp_call_count = res_ff.count;
   assign rsp_min_secs   = res_ff.min_s;
   assign rsp_min_nsecs  = res_ff.min_n;
   assign rsp_max_secs   = res_ff.max_s;
   assign rsp_max_nsecs  = res_ff.max_n;
   assign rsp_avg_10us   = avg_ff;

   a_no_take_in_init: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !wk_take) else $error("item taken during clearing pass");
   a_update_after_fetch: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> $past(state_ff) == ST_FETCH)
      else $error("update without fetch");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !out_valid_in || !out_valid_ff || rsp_stall)
      else $error("result raised during clear");

endmodule

// ----- sv/rpc_reply_latency_stats_table.sv -----
// ----------------------------------------------------------------------------
// rpc_reply_latency_stats_table: per-procedure RPC round-trip statistics
//
//   channel  ports   handshake        content
//   input    req_*   valid / stall    command, procedure, packet and times
//   result   rsp_*   valid / stall    accepted, count, min, max, average
//   config   csr_*   valid / ready    index 0 program, 1 version, 2 count
//
// A sample is a table read and an update write; a read runs the bit-serial
// 64/32 average divider; a clear sweeps 256 entries, one entry a cycle.
// After reset a clearing pass over all entries runs before the first item is taken.
// Reset is synchronous. The front accepts and queues up to three items while
// the back or the result side is stalled.
// ----------------------------------------------------------------------------
module rpc_reply_latency_stats_table import rrls_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [7:0]         req_procedure,
   input  logic               req_is_request,
   input  logic [31:0]        req_packet_program,
   input  logic [31:0]        req_packet_version,
   input  logic [31:0]        req_reply_secs,
   input  logic [19:0]        req_reply_usecs,
   input  logic [31:0]        req_call_secs,
   input  logic [29:0]        req_call_nsecs,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_accepted,
   output logic [31:0]        rsp_call_count,
   output logic signed [31:0] rsp_min_secs,
   output logic [29:0]        rsp_min_nsecs,
   output logic signed [31:0] rsp_max_secs,
   output logic [29:0]        rsp_max_nsecs,
   output logic [63:0]        rsp_avg_10us,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic [31:0] prog_ff, vers_ff;
   logic [8:0]  pcount_ff;
   logic        fq_valid, fq_stall, qb_valid, qb_take;
   work_type    fq_item, qb_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_ff <= '0; vers_ff <= '0; pcount_ff <= '0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_PROGRAM:    prog_ff   <= csr_data;
            CSR_VERSION:    vers_ff   <= csr_data;
            CSR_PROC_COUNT: pcount_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   rrls_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_procedure,
      .req_is_request, .req_packet_program, .req_packet_version,
      .req_reply_secs, .req_reply_usecs, .req_call_secs, .req_call_nsecs,
      .prog_ff, .vers_ff, .pcount_ff,
      .wk_valid(fq_valid), .wk_stall(fq_stall), .wk_item(fq_item)
   );

   rrls_queue u_queue (
      .clock, .reset,
      .in_valid(fq_valid), .in_stall(fq_stall), .in_item(fq_item),
      .out_valid(qb_valid), .out_take(qb_take), .out_item(qb_item)
   );

   rrls_back u_back (
      .clock, .reset,
      .wk_valid(qb_valid), .wk_take(qb_take), .wk_item(qb_item),
      .rsp_valid, .rsp_stall, .rsp_accepted, .rsp_call_count,
      .rsp_min_secs, .rsp_min_nsecs, .rsp_max_secs, .rsp_max_nsecs,
      .rsp_avg_10us
   );

endmodule
